/* rtl/dlsw_pkg.sv */
// shared constants, image type and glyph table for the decimal lcd segment writer
// no dependencies
package dlsw_pkg;

  localparam int NUM_DIGITS_DEF    = 6;
  localparam int VALUE_BITS_DEF    = 31;
  localparam int DISPLAY_POSITIONS = 6;
  localparam int ROWS              = 4;
  localparam int BYTES_PER_ROW     = 3;
  localparam int INPUT_BITS        = 31;

  // divide by ten: q = (v * 0xcccccccd) >> 35, exact for any 32-bit v
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  // four rows of three bytes each
  typedef logic [ROWS-1:0][BYTES_PER_ROW-1:0][7:0] image_t;

  // glyph for one decimal digit, nibble r goes to common row r
  function automatic logic [15:0] glyph(input logic [3:0] digit);
    logic [15:0] g;
    case (digit)
      4'd0:    g = 16'h1551;
      4'd1:    g = 16'h2080;
      4'd2:    g = 16'h1E11;
      4'd3:    g = 16'h1B11;
      4'd4:    g = 16'h0B50;
      4'd5:    g = 16'h1B41;
      4'd6:    g = 16'h1F41;
      4'd7:    g = 16'h0111;
      4'd8:    g = 16'h1F51;
      4'd9:    g = 16'h0B51;
      default: g = 16'h0000;
    endcase
    return g;
  endfunction

endpackage

/* rtl/dlsw_digit_stage.sv */
// one decimal digit: reciprocal multiply stage, then digit split and glyph placement stage
// depends on dlsw_pkg
module dlsw_digit_stage #(
  parameter int VALUE_BITS = dlsw_pkg::VALUE_BITS_DEF,
  parameter int DIGIT_IDX  = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_vld,
  input  logic [VALUE_BITS-1:0] in_val,
  input  dlsw_pkg::image_t      in_img,
  output logic                  out_vld,
  output logic [VALUE_BITS-1:0] out_val,
  output dlsw_pkg::image_t      out_img
);
  import dlsw_pkg::*;

  localparam int PW      = VALUE_BITS + 32;
  localparam int QW      = VALUE_BITS - 3;
  localparam int POS     = DISPLAY_POSITIONS - 1 - DIGIT_IDX;
  localparam int BYTE_IX = POS / 2;
  localparam int NIB_LSB = 4 * (POS % 2);

  // multiply stage
  logic                  vld_a_r;
  logic [VALUE_BITS-1:0] v_a_r;
  logic [PW-1:0]         prod_a_r;
  image_t                img_a_r;

  // placement stage
  logic                  vld_b_r;
  logic [VALUE_BITS-1:0] q_b_r;
  image_t                img_b_r;

  logic [QW-1:0]         quo;
  logic [VALUE_BITS-1:0] quo_ext;
  logic [VALUE_BITS-1:0] rem_full;
  logic [3:0]            rem;
  logic [15:0]           gl;
  logic                  show;
  image_t                img_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else if (adv) begin
      vld_a_r <= in_vld;
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v_a_r    <= in_val;
      prod_a_r <= PW'(in_val) * PW'(RECIP_TEN);
      img_a_r  <= in_img;
      q_b_r    <= quo_ext;
      img_b_r  <= img_nxt;
    end
  end

  always_comb begin
    quo      = prod_a_r[PW-1:RECIP_SHIFT];
    quo_ext  = VALUE_BITS'(quo);
    rem_full = v_a_r - ((quo_ext << 3) + (quo_ext << 1));
    rem      = rem_full[3:0];
    gl       = glyph(rem);
    // lowest digit always shows, higher ones only while digits remain
    show     = (DIGIT_IDX == 0) || (v_a_r != '0);
    img_nxt  = img_a_r;
    if (show) begin
      for (int r = 0; r < ROWS; r++) begin
        img_nxt[r][BYTE_IX][NIB_LSB +: 4] = img_a_r[r][BYTE_IX][NIB_LSB +: 4] | gl[4*r +: 4];
      end
    end
  end

  assign out_vld = vld_b_r;
  assign out_val = q_b_r;
  assign out_img = img_b_r;

  a_rem_decimal : assert property (@(posedge clk) disable iff (!rst_n)
    vld_a_r |-> (rem < 4'd10))
    else $error("digit remainder out of decimal range");

  a_valid_moves : assert property (@(posedge clk) disable iff (!rst_n)
    (adv && vld_a_r) |=> vld_b_r)
    else $error("valid lost between multiply and placement stage");

  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && vld_b_r) |=> (vld_b_r && $stable(img_b_r) && $stable(q_b_r)))
    else $error("placement stage changed during stall");

endmodule

/* rtl/decimal_lcd_segment_writer.sv */
// throughput: one transfer per cycle while the output is not stalled; two register
//   stages per digit (reciprocal multiply, then remainder and glyph placement),
//   NUM_DIGITS such pairs in a row
// a stalled output freezes the whole pipeline; in_ready follows out_ready combinationally
// reset (rst_n low, synchronous) clears the valid bits only; no other state
module decimal_lcd_segment_writer #(
  parameter int NUM_DIGITS = dlsw_pkg::NUM_DIGITS_DEF,
  parameter int VALUE_BITS = dlsw_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [dlsw_pkg::INPUT_BITS-1:0] in_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_row0_byte0,
  output logic [7:0]                      out_row0_byte1,
  output logic [7:0]                      out_row0_byte2,
  output logic [7:0]                      out_row1_byte0,
  output logic [7:0]                      out_row1_byte1,
  output logic [7:0]                      out_row1_byte2,
  output logic [7:0]                      out_row2_byte0,
  output logic [7:0]                      out_row2_byte1,
  output logic [7:0]                      out_row2_byte2,
  output logic [7:0]                      out_row3_byte0,
  output logic [7:0]                      out_row3_byte1,
  output logic [7:0]                      out_row3_byte2
);
  import dlsw_pkg::*;

  // chain taps: index k feeds digit stage k, index NUM_DIGITS is the result
  logic                  vld_c [NUM_DIGITS+1];
  logic [VALUE_BITS-1:0] val_c [NUM_DIGITS+1];
  image_t                img_c [NUM_DIGITS+1];
  logic                  adv;
  image_t                img_out;

  // the last placement register doubles as the output register; every stage
  // moves when the result slot is empty or being taken by a transfer
  assign adv      = !vld_c[NUM_DIGITS] || out_ready;
  assign in_ready = adv;

  // only the low VALUE_BITS bits of the number count, image starts blank
  assign vld_c[0] = in_valid;
  assign val_c[0] = in_value[VALUE_BITS-1:0];
  assign img_c[0] = '0;

  for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_digit
    dlsw_digit_stage #(
      .VALUE_BITS (VALUE_BITS),
      .DIGIT_IDX  (k)
    ) u_digit (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .in_vld  (vld_c[k]),
      .in_val  (val_c[k]),
      .in_img  (img_c[k]),
      .out_vld (vld_c[k+1]),
      .out_val (val_c[k+1]),
      .out_img (img_c[k+1])
    );
  end

  // the quotient left after the last digit is dropped: higher digits are not shown
  assign img_out   = img_c[NUM_DIGITS];
  assign out_valid = vld_c[NUM_DIGITS];

  assign out_row0_byte0 = img_out[0][0];
  assign out_row0_byte1 = img_out[0][1];
  assign out_row0_byte2 = img_out[0][2];
  assign out_row1_byte0 = img_out[1][0];
  assign out_row1_byte1 = img_out[1][1];
  assign out_row1_byte2 = img_out[1][2];
  assign out_row2_byte0 = img_out[2][0];
  assign out_row2_byte1 = img_out[2][1];
  assign out_row2_byte2 = img_out[2][2];
  assign out_row3_byte0 = img_out[3][0];
  assign out_row3_byte1 = img_out[3][1];
  assign out_row3_byte2 = img_out[3][2];

  // the rightmost position always carries a digit, so its nibbles are never all blank
  a_units_shown : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_row0_byte2[7:4] | out_row1_byte2[7:4] |
                    out_row2_byte2[7:4] | out_row3_byte2[7:4]) != 4'd0))
    else $error("result without a units digit");

  // a transfer in while the result is stalled would be lost
  a_no_take_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while pipeline stalled");

endmodule

/* sim/tb.sv */
// testbench for decimal_lcd_segment_writer: drives values in decimal size classes
// and checks each lcd image against an in-bench predictor of the digit and glyph layout
// depends on dlsw_pkg and the decimal_lcd_segment_writer rtl
`timescale 1ns / 1ps

module tb;
  import dlsw_pkg::*;

  localparam int LATENCY     = 2 * NUM_DIGITS_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int GAP_PERCENT = 36;
  localparam int MAX_REPORTS = 10;

  // glyph per digit, index 0 in the lowest slot
  localparam logic [9:0][15:0] GLYPH_ROM = {
    16'h0B51, 16'h1F51, 16'h0111, 16'h1F41, 16'h1B41,
    16'h0B50, 16'h1B11, 16'h1E11, 16'h2080, 16'h1551
  };

  typedef struct packed {
    logic [INPUT_BITS-1:0] value;
    image_t                img;
  } lcd_expect_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [INPUT_BITS-1:0] in_value  = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  image_t                out_img;

  lcd_expect_t pending_images[$];

  // stimulus controls, set by the test tasks; the receiver clears hold_req after its hold-off
  bit gaps_on  = 1'b1;
  bit hold_req = 1'b0;

  int unsigned values_sent    = 0;
  int unsigned images_checked = 0;
  int unsigned mismatches     = 0;
  int unsigned stall_cycles   = 0;

  decimal_lcd_segment_writer i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row0_byte0 (out_img[0][0]),
    .out_row0_byte1 (out_img[0][1]),
    .out_row0_byte2 (out_img[0][2]),
    .out_row1_byte0 (out_img[1][0]),
    .out_row1_byte1 (out_img[1][1]),
    .out_row1_byte2 (out_img[1][2]),
    .out_row2_byte0 (out_img[2][0]),
    .out_row2_byte1 (out_img[2][1]),
    .out_row2_byte2 (out_img[2][2]),
    .out_row3_byte0 (out_img[3][0]),
    .out_row3_byte1 (out_img[3][1]),
    .out_row3_byte2 (out_img[3][2])
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // expected lcd image: lowest digit at the rightmost position, higher digits
  // fill leftwards, no leading zeros, zero shows a single 0
  function automatic image_t lcd_image(input logic [INPUT_BITS-1:0] value);
    image_t      img;
    int unsigned rest;
    int unsigned digit;
    int          pos;
    int          k;
    int          r;
    bit          done;
    logic [15:0] g;
    img  = '0;
    rest = value & ((32'd1 << VALUE_BITS_DEF) - 32'd1);
    done = 1'b0;
    for (k = 0; k < NUM_DIGITS_DEF && k < DISPLAY_POSITIONS; k++) begin
      if (!done) begin
        digit = rest % 10;
        pos   = DISPLAY_POSITIONS - 1 - k;
        g     = GLYPH_ROM[digit];
        // nibble r of the glyph goes to common row r; odd positions take the high nibble
        for (r = 0; r < ROWS; r++) begin
          if (pos % 2 == 1)
            img[r][pos / 2][7:4] = img[r][pos / 2][7:4] | g[4*r +: 4];
          else
            img[r][pos / 2][3:0] = img[r][pos / 2][3:0] | g[4*r +: 4];
        end
        rest = rest / 10;
        if (rest == 0)
          done = 1'b1;
      end
    end
    return img;
  endfunction

  // random value, mostly of a chosen decimal length so that every digit count turns up
  function automatic logic [INPUT_BITS-1:0] rand_value();
    longint      lo;
    longint      hi;
    int          ndig;
    int          k;
    lo = 1;
    if ($urandom_range(0, 3) == 0)
      return INPUT_BITS'($urandom);
    ndig = $urandom_range(1, 10);
    for (k = 1; k < ndig; k++)
      lo = lo * 10;
    hi = lo * 10 - 1;
    if (ndig == 1)
      lo = 0;
    if (hi > 64'd2147483647)
      hi = 64'd2147483647;
    return INPUT_BITS'($urandom_range(int'(hi), int'(lo)));
  endfunction

  // offer one value and hold it until the transfer happens
  task automatic send_value(input logic [INPUT_BITS-1:0] v);
    while (gaps_on && $urandom_range(0, 99) < GAP_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
  endtask

  // sender goes idle and stays quiet until every outstanding image has arrived
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_images.size() != 0)
      @(posedge clk);
  endtask

  // receiver: random stalls, or one long hold-off when a test asks for it
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 99) < GAP_PERCENT) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // input side: predict the image for each accepted value
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      pending_images.push_back('{value: in_value, img: lcd_image(in_value)});
      values_sent++;
    end
  end

  // output side: compare each image with the oldest prediction, byte by byte
  always @(posedge clk) begin
    lcd_expect_t exp_item;
    int          bad_bytes;
    if (rst_n && out_valid && out_ready) begin
      images_checked++;
      if (pending_images.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected image %h with nothing outstanding", out_img);
      end else begin
        exp_item  = pending_images.pop_front();
        bad_bytes = 0;
        for (int r = 0; r < ROWS; r++)
          for (int b = 0; b < BYTES_PER_ROW; b++)
            if (out_img[r][b] !== exp_item.img[r][b])
              bad_bytes++;
        if (bad_bytes != 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("value %0d: %0d bytes wrong, expected %h actual %h",
                     exp_item.value, bad_bytes, exp_item.img, out_img);
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", stall_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // extremes, every digit in several positions, digit dropping and blanking
  task automatic test_directed();
    logic [INPUT_BITS-1:0] vals[$];
    vals = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 99, 100, 100000, 999999,
             1000000, 123456, 789012, 345678, 901234, 1234567,
             31'h7FFF_FFFF, 31'h4000_0000, 31'h5555_5555, 31'h2AAA_AAAA};
    foreach (vals[i])
      send_value(vals[i]);
  endtask

  // random values with random idling on both sides
  task automatic test_random(input int count);
    repeat (count)
      send_value(rand_value());
  endtask

  // back-to-back transfers with neither side idling
  task automatic test_burst(input int count);
    gaps_on = 1'b0;
    repeat (count)
      send_value(rand_value());
    gaps_on = 1'b1;
  endtask

  // receiver holds off long enough for the pipeline to fill and stall the input
  task automatic test_backpressure(input int count);
    hold_req = 1'b1;
    repeat (count)
      send_value(rand_value());
  endtask

  // sender pauses mid-stream until all images are out, then resumes
  task automatic test_drain_pause(input int count);
    repeat (count)
      send_value(rand_value());
    wait_drain();
    repeat (count)
      send_value(rand_value());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(200);
    test_burst(150);
    test_backpressure(40);
    test_drain_pause(20);
    test_random(180);

    wait_drain();
    repeat (2 * LATENCY) @(posedge clk);

    $display("sent %0d values and checked %0d lcd images, %0d mismatches",
             values_sent, images_checked, mismatches);
    $display("covered all digits and lengths, digit dropping, bursts and long back-pressure");
    if (mismatches == 0 && pending_images.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
